>>> design/tro_pkg.sv
// ----------------------------------------------------------------------------
// Telnet receive option engine package
// Shared types and protocol constants for the decoder and the top level.
// ----------------------------------------------------------------------------
package tro_pkg;

  // Telnet command bytes
  localparam logic [7:0] CH_IAC   = 8'd255;
  localparam logic [7:0] CH_WILL  = 8'd251;
  localparam logic [7:0] CH_WONT  = 8'd252;
  localparam logic [7:0] CH_DO    = 8'd253;
  localparam logic [7:0] CH_DONT  = 8'd254;
  localparam logic [7:0] CH_DMARK = 8'd242;
  localparam logic [7:0] CH_IP    = 8'd244;
  localparam logic [7:0] CH_AO    = 8'd245;
  localparam logic [7:0] CH_EC    = 8'd247;
  localparam logic [7:0] CH_EL    = 8'd248;
  localparam logic [7:0] CH_NOP   = 8'd241;
  localparam logic [7:0] CH_GA    = 8'd249;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // Option codes; binary, echo and suppress-go-ahead have a policy of their own
  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TM     = 8'd6;

  localparam logic [1:0] ECHO_RAW_NOECHO = 2'd1;
  localparam logic [1:0] ECHO_RAW_ECHO   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_INTERRUPT = 2'd0;
  localparam logic [1:0] REG_ERASE     = 2'd1;
  localparam logic [1:0] REG_KILL      = 2'd2;
  localparam logic [1:0] REG_FLUSH     = 2'd3;

  localparam int unsigned MaxRes = 3;

  typedef enum logic [1:0] {
    PH_DATA = 2'd0,
    PH_CMD  = 2'd1,
    PH_OPT  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_e;

  typedef enum logic [1:0] {
    KIND_TERM  = 2'd0,
    KIND_NET   = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  // Only binary, echo and suppress-go-ahead entries of the option tables can
  // ever become set; every other entry stays clear from reset onwards.
  typedef struct packed {
    logic sga;
    logic echo;
    logic bin;
  } opt_t;

  typedef struct packed {
    phase_e     phase;
    verb_e      verb;
    logic [7:0] prev;
    opt_t       peer;
    opt_t       local_opt;
    logic       ga;
    logic [1:0] echo;
  } st_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic       push;
  } res_t;

  typedef struct packed {
    logic [7:0] intr;
    logic [7:0] erase;
    logic [7:0] kill;
    logic [7:0] flush;
  } cfg_t;

endpackage

>>> design/tro_decode.sv
// ----------------------------------------------------------------------------
// Telnet receive option engine decoder
// Parses one received byte or idle event against the current state and gives
// the next state together with up to three result entries.
// ----------------------------------------------------------------------------
module tro_decode (
  input  logic                                 cmd_i,
  input  logic [7:0]                           byte_i,
  input  tro_pkg::st_t                         st_i,
  input  tro_pkg::cfg_t                        cfg_i,
  output tro_pkg::st_t                         st_o,
  output tro_pkg::res_t [tro_pkg::MaxRes-1:0]  res_o,
  output logic [1:0]                           n_res_o
);

  logic is_bin, is_echo, is_sga, policy_opt;
  logic peer_c, local_c;
  logic reply;
  logic [7:0] reply_verb;

  assign is_bin     = (byte_i == tro_pkg::OPT_BINARY);
  assign is_echo    = (byte_i == tro_pkg::OPT_ECHO);
  assign is_sga     = (byte_i == tro_pkg::OPT_SGA);
  assign policy_opt = is_bin | is_sga;

  assign peer_c  = (is_bin & st_i.peer.bin) | (is_echo & st_i.peer.echo) |
                   (is_sga & st_i.peer.sga);
  assign local_c = (is_bin & st_i.local_opt.bin) | (is_echo & st_i.local_opt.echo) |
                   (is_sga & st_i.local_opt.sga);

  always_comb begin
    st_o       = st_i;
    reply      = 1'b0;
    reply_verb = tro_pkg::CH_WONT;
    res_o      = '0;
    n_res_o    = 2'd0;

    if (cmd_i) begin
      if (st_i.phase == tro_pkg::PH_DATA && st_i.ga) begin
        res_o[0] = '{tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0};
        res_o[1] = '{tro_pkg::KIND_NET, tro_pkg::CH_GA, 1'b1};
        n_res_o  = 2'd2;
      end
    end else begin
      case (st_i.phase)
        tro_pkg::PH_DATA: begin
          if (byte_i == tro_pkg::CH_IAC) begin
            st_o.phase = tro_pkg::PH_CMD;
          end else begin
            // drop NUL or LF straight after CR
            if (st_i.prev != tro_pkg::CH_CR ||
                (byte_i != tro_pkg::CH_LF && byte_i != tro_pkg::CH_NUL)) begin
              res_o[0] = '{tro_pkg::KIND_TERM, byte_i, 1'b0};
              n_res_o  = 2'd1;
            end
            st_o.prev = byte_i;
          end
        end
        tro_pkg::PH_CMD: begin
          st_o.phase = tro_pkg::PH_DATA;
          case (byte_i)
            tro_pkg::CH_WILL, tro_pkg::CH_WONT, tro_pkg::CH_DO, tro_pkg::CH_DONT: begin
              st_o.verb  = tro_pkg::verb_e'(2'(byte_i - tro_pkg::CH_WILL));
              st_o.phase = tro_pkg::PH_OPT;
            end
            tro_pkg::CH_DMARK: begin
              res_o[0] = '{tro_pkg::KIND_FLUSH, 8'd0, 1'b0};
              n_res_o  = 2'd1;
            end
            tro_pkg::CH_IP: begin
              res_o[0] = '{tro_pkg::KIND_TERM, cfg_i.intr, 1'b0};
              n_res_o  = 2'd1;
            end
            tro_pkg::CH_EC: begin
              res_o[0] = '{tro_pkg::KIND_TERM, cfg_i.erase, 1'b0};
              n_res_o  = 2'd1;
            end
            tro_pkg::CH_EL: begin
              res_o[0] = '{tro_pkg::KIND_TERM, cfg_i.kill, 1'b0};
              n_res_o  = 2'd1;
            end
            tro_pkg::CH_AO: begin
              res_o[0] = '{tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0};
              res_o[1] = '{tro_pkg::KIND_NET, tro_pkg::CH_DMARK, 1'b1};
              res_o[2] = '{tro_pkg::KIND_TERM, cfg_i.flush, 1'b0};
              n_res_o  = 2'd3;
            end
            default: ;
          endcase
        end
        tro_pkg::PH_OPT: begin
          st_o.phase = tro_pkg::PH_DATA;
          case (st_i.verb)
            tro_pkg::VERB_WILL: begin
              if (!peer_c) begin
                reply = 1'b1;
                if (policy_opt) begin
                  reply_verb = tro_pkg::CH_DO;
                  if (is_bin) st_o.peer.bin = 1'b1;
                  if (is_sga) st_o.peer.sga = 1'b1;
                end else begin
                  reply_verb = tro_pkg::CH_DONT;
                end
              end
            end
            tro_pkg::VERB_WONT: begin
              if (peer_c) begin
                reply      = 1'b1;
                reply_verb = tro_pkg::CH_DONT;
                // echo entry stays set on refusal
                if (is_bin) st_o.peer.bin = 1'b0;
                if (is_sga) st_o.peer.sga = 1'b0;
              end
            end
            tro_pkg::VERB_DO: begin
              if (!local_c) begin
                reply = 1'b1;
                if (is_echo || policy_opt) begin
                  reply_verb = tro_pkg::CH_WILL;
                end else begin
                  reply_verb = tro_pkg::CH_WONT;
                end
                if (is_echo) begin
                  st_o.echo           = tro_pkg::ECHO_RAW_ECHO;
                  st_o.local_opt.echo = 1'b1;
                  st_o.peer.echo      = 1'b0;
                end
                if (is_sga) begin
                  st_o.local_opt.sga = 1'b1;
                  st_o.ga            = 1'b0;
                end
                if (is_bin) st_o.local_opt.bin = 1'b1;
              end
            end
            default: begin
              if (local_c) begin
                reply      = 1'b1;
                reply_verb = tro_pkg::CH_WONT;
                if (is_echo) begin
                  st_o.echo           = tro_pkg::ECHO_RAW_NOECHO;
                  st_o.local_opt.echo = 1'b0;
                  st_o.peer.echo      = 1'b1;
                end
                if (is_sga) begin
                  st_o.local_opt.sga = 1'b0;
                  st_o.ga            = 1'b1;
                end
                if (is_bin) st_o.local_opt.bin = 1'b0;
              end
            end
          endcase
          if (reply) begin
            res_o[0] = '{tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0};
            res_o[1] = '{tro_pkg::KIND_NET, reply_verb, 1'b0};
            res_o[2] = '{tro_pkg::KIND_NET, byte_i, 1'b1};
            n_res_o  = 2'd3;
          end
        end
        default: begin
          st_o.phase = tro_pkg::PH_DATA;
        end
      endcase
    end
  end

endmodule

>>> design/telnet_receive_option_engine_unit.sv
// ----------------------------------------------------------------------------
// Telnet receive option engine
// Server-side telnet receive parser with option negotiation replies.
// ----------------------------------------------------------------------------
// Input stream: one request per received network byte (s_axis_tuser = 0) or
// per receive-buffer-empty event (s_axis_tuser = 1). Output stream: result
// requests, tuser giving the kind (terminal byte, network byte, flush) and
// tlast marking the final result of one input request.
// An accepted request sits in the input register; the decoder works on it
// combinationally, and once the result buffer is empty or hands over its
// final result, up to three results load into the buffer register, which
// offers the first. The buffer presents one result per cycle while the
// master side is ready, so an input holds it for as many results as it
// gives; a negotiation reply of three bytes sets the worst case.
// The input register accepts a new request while results still wait, and a
// stalled master side holds the buffer and then the input register.
// Reset clears the parse state and the option tables, sets go-ahead on and
// echo mode to raw echo, and loads the terminal characters with their
// defaults. Configuration writes are taken at once while the block is idle.
// ----------------------------------------------------------------------------
module telnet_receive_option_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] value, [8] push_packet,
                                      // [10:9] echo_mode, [11] go_ahead,
                                      // [12] binary_tx, [15:13] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  tro_pkg::cfg_t cfg_q;
  tro_pkg::st_t  st_q, st_d;

  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;

  tro_pkg::res_t [tro_pkg::MaxRes-1:0] res_d, res_q;
  logic [1:0] n_res_d, cnt_q;
  logic [1:0] echo_q;
  logic       ga_q, bin_q;
  logic       load, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.intr  <= 8'd127;
      cfg_q.erase <= 8'd35;
      cfg_q.kill  <= 8'd64;
      cfg_q.flush <= 8'd15;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tro_pkg::REG_INTERRUPT: cfg_q.intr  <= cfg_data_i;
        tro_pkg::REG_ERASE:     cfg_q.erase <= cfg_data_i;
        tro_pkg::REG_KILL:      cfg_q.kill  <= cfg_data_i;
        tro_pkg::REG_FLUSH:     cfg_q.flush <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tro_decode u_decode (
    .cmd_i   (in_cmd_q),
    .byte_i  (in_byte_q),
    .st_i    (st_q),
    .cfg_i   (cfg_q),
    .st_o    (st_d),
    .res_o   (res_d),
    .n_res_o (n_res_d)
  );

  assign pop  = m_axis_tvalid & m_axis_tready;
  // load once the buffer is empty or hands over its final result
  assign load = in_valid_q & ((cnt_q == 2'd0) | ((cnt_q == 2'd1) & m_axis_tready));
  assign s_axis_tready = ~in_valid_q | load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase     <= tro_pkg::PH_DATA;
      st_q.verb      <= tro_pkg::VERB_WILL;
      st_q.prev      <= 8'd0;
      st_q.peer      <= '0;
      st_q.local_opt <= '0;
      st_q.ga        <= 1'b1;
      st_q.echo      <= tro_pkg::ECHO_RAW_ECHO;
      cnt_q          <= 2'd0;
    end else if (load) begin
      st_q  <= st_d;
      cnt_q <= n_res_d;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res_d;
      echo_q <= st_d.echo;
      ga_q   <= st_d.ga;
      bin_q  <= st_d.local_opt.bin;
    end else if (pop) begin
      // advance the burst by one entry
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tlast  = (cnt_q == 2'd1);
  assign m_axis_tuser  = res_q[0].kind;
  assign m_axis_tdata  = {3'b000, bin_q, ga_q, echo_q, res_q[0].push, res_q[0].value};

  a_net_last_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser == tro_pkg::KIND_NET
      |-> m_axis_tdata[8])
    else $error("final network byte of a burst without push");

  a_term_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != tro_pkg::KIND_NET |-> !m_axis_tdata[8])
    else $error("push set on a terminal result");

  a_ga_vs_sga : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ga == !st_q.local_opt.sga)
    else $error("go-ahead out of step with local suppress-go-ahead");

  a_echo_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.local_opt.echo |-> st_q.echo == tro_pkg::ECHO_RAW_ECHO)
    else $error("local echo agreed without raw echo mode");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(cnt_q))
    else $error("result buffer changed under a stall");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Telnet receive option engine testbench
// Drives received bytes and idle events into the engine and checks every
// terminal, network and flush result against a cycle-free model of the parser
// and its option tables, or the table for typed rows. A short directed table
// comes first. Three random phases follow, each with its own terminal
// characters and its own amount of idling on the input and output streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 300;
  localparam int CycleLimit = 200000;
  localparam int DrainLimit = 5000;
  localparam int Settle     = 8;
  localparam int PhaseItems = 95;
  localparam int MaxPrints  = 40;

  typedef struct packed {
    logic                   cmd;
    logic [7:0]             b;
    logic                   typed;
    logic [1:0]             n;
    tro_pkg::res_t [0:2]    r;
  } dir_row_t;

  typedef struct {
    tro_pkg::res_t res;
    logic          last;
    logic [1:0]    echo;
    logic          ga;
    logic          bin;
  } out_item_t;

  localparam tro_pkg::res_t       Nil    = '0;
  localparam tro_pkg::res_t       NetIac = '{tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0};
  localparam tro_pkg::res_t [0:2] NoRes  = '{Nil, Nil, Nil};

  // Rows marked typed carry their results; the rest go through the model
  localparam dir_row_t DirTable [26] = '{
    '{1'b0, 8'hFE, 1'b1, 2'd1, '{'{tro_pkg::KIND_TERM, 8'hFE, 1'b0}, Nil, Nil}},
    '{1'b1, 8'h00, 1'b1, 2'd2,
      '{NetIac, '{tro_pkg::KIND_NET, tro_pkg::CH_GA, 1'b1}, Nil}},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_IP,    1'b1, 2'd1,
      '{'{tro_pkg::KIND_TERM, 8'd127, 1'b0}, Nil, Nil}},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_AO,    1'b1, 2'd3,
      '{NetIac, '{tro_pkg::KIND_NET, tro_pkg::CH_DMARK, 1'b1},
        '{tro_pkg::KIND_TERM, 8'd15, 1'b0}}},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_DMARK, 1'b1, 2'd1,
      '{'{tro_pkg::KIND_FLUSH, 8'd0, 1'b0}, Nil, Nil}},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b1, 8'hFF,             1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_EC,    1'b1, 2'd1,
      '{'{tro_pkg::KIND_TERM, 8'd35, 1'b0}, Nil, Nil}},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_EL,    1'b1, 2'd1,
      '{'{tro_pkg::KIND_TERM, 8'd64, 1'b0}, Nil, Nil}},
    '{1'b0, tro_pkg::CH_CR,    1'b1, 2'd1,
      '{'{tro_pkg::KIND_TERM, tro_pkg::CH_CR, 1'b0}, Nil, Nil}},
    '{1'b0, tro_pkg::CH_LF,    1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_CR,    1'b1, 2'd1,
      '{'{tro_pkg::KIND_TERM, tro_pkg::CH_CR, 1'b0}, Nil, Nil}},
    '{1'b0, tro_pkg::CH_NUL,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_IAC,   1'b1, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_IAC,   1'b0, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_DO,    1'b0, 2'd0, NoRes},
    '{1'b0, tro_pkg::OPT_SGA,  1'b0, 2'd0, NoRes},
    '{1'b1, 8'h5A,             1'b0, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_IAC,   1'b0, 2'd0, NoRes},
    '{1'b0, tro_pkg::CH_WILL,  1'b0, 2'd0, NoRes},
    '{1'b0, 8'hFF,             1'b0, 2'd0, NoRes}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = tro_pkg::REG_INTERRUPT;
  logic [7:0]  cfg_data_i    = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
  logic        s_axis_tuser  = 1'b0;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] value, [8] push_packet,
                                       // [10:9] echo_mode, [11] go_ahead,
                                       // [12] binary_tx, [15:13] zero
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  // Model of the parser
  tro_pkg::phase_e rx_phase  = tro_pkg::PH_DATA;
  tro_pkg::verb_e  pend_verb = tro_pkg::VERB_WILL;
  logic [7:0]      prev_ch   = 8'd0;
  bit              peer_on  [256];
  bit              local_on [256];
  logic            ga_on     = 1'b1;
  logic [1:0]      echo_mode = tro_pkg::ECHO_RAW_ECHO;
  tro_pkg::cfg_t   chars     = '{8'd127, 8'd35, 8'd64, 8'd15};

  tro_pkg::res_t step_out [$];
  out_item_t     awaited  [$];

  int src_gap_pct  = 21;
  int sink_gap_pct = 54;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;
  int sent         = 0;
  int checked      = 0;
  int replies      = 0;
  int errors       = 0;
  int cycles       = 0;

  telnet_receive_option_engine_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic report(string field, int got, int want);
    errors++;
    if (errors <= MaxPrints) begin
      $display("tb_top: %s mismatch at result %0d: got %0h, expected %0h",
               field, checked, got, want);
    end
  endtask

  task automatic queue_out(tro_pkg::kind_e k, logic [7:0] v, logic p);
    step_out.push_back(tro_pkg::res_t'{k, v, p});
  endtask

  task automatic queue_reply(logic [7:0] verb, logic [7:0] opt);
    queue_out(tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0);
    queue_out(tro_pkg::KIND_NET, verb, 1'b0);
    queue_out(tro_pkg::KIND_NET, opt, 1'b1);
    replies++;
  endtask

  task automatic settle_option(logic [7:0] c);
    case (pend_verb)
      tro_pkg::VERB_WILL: begin
        if (!peer_on[c]) begin
          if (c == tro_pkg::OPT_SGA || c == tro_pkg::OPT_BINARY) begin
            peer_on[c] = 1'b1;
            queue_reply(tro_pkg::CH_DO, c);
          end else begin
            queue_reply(tro_pkg::CH_DONT, c);
          end
        end
      end
      tro_pkg::VERB_WONT: begin
        // refusal of other options is answered but the entry stays set
        if (peer_on[c]) begin
          queue_reply(tro_pkg::CH_DONT, c);
          if (c == tro_pkg::OPT_SGA || c == tro_pkg::OPT_BINARY) peer_on[c] = 1'b0;
        end
      end
      tro_pkg::VERB_DO: begin
        if (!local_on[c]) begin
          if (c == tro_pkg::OPT_ECHO) begin
            echo_mode = tro_pkg::ECHO_RAW_ECHO;
            queue_reply(tro_pkg::CH_WILL, c);
            local_on[c] = 1'b1;
            peer_on[c]  = 1'b0;
          end else if (c == tro_pkg::OPT_SGA) begin
            queue_reply(tro_pkg::CH_WILL, c);
            local_on[c] = 1'b1;
            ga_on       = 1'b0;
          end else if (c == tro_pkg::OPT_BINARY) begin
            queue_reply(tro_pkg::CH_WILL, c);
            local_on[c] = 1'b1;
          end else begin
            queue_reply(tro_pkg::CH_WONT, c);
          end
        end
      end
      default: begin
        if (local_on[c]) begin
          local_on[c] = 1'b0;
          if (c == tro_pkg::OPT_ECHO) begin
            echo_mode  = tro_pkg::ECHO_RAW_NOECHO;
            peer_on[c] = 1'b1;
          end else if (c == tro_pkg::OPT_SGA) begin
            ga_on = 1'b1;
          end
          queue_reply(tro_pkg::CH_WONT, c);
        end
      end
    endcase
  endtask

  task automatic decode_rx_request(logic cmd, logic [7:0] b);
    logic [7:0] off;
    step_out.delete();
    off = b - tro_pkg::CH_WILL;
    if (cmd) begin
      // idle event: go-ahead only between sequences
      if (rx_phase == tro_pkg::PH_DATA && ga_on) begin
        queue_out(tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0);
        queue_out(tro_pkg::KIND_NET, tro_pkg::CH_GA, 1'b1);
      end
    end else if (rx_phase == tro_pkg::PH_DATA) begin
      if (b == tro_pkg::CH_IAC) begin
        rx_phase = tro_pkg::PH_CMD;
      end else begin
        if (prev_ch != tro_pkg::CH_CR || (b != tro_pkg::CH_LF && b != tro_pkg::CH_NUL)) begin
          queue_out(tro_pkg::KIND_TERM, b, 1'b0);
        end
        prev_ch = b;
      end
    end else if (rx_phase == tro_pkg::PH_CMD) begin
      rx_phase = tro_pkg::PH_DATA;
      case (b)
        tro_pkg::CH_WILL, tro_pkg::CH_WONT, tro_pkg::CH_DO, tro_pkg::CH_DONT: begin
          pend_verb = tro_pkg::verb_e'(off[1:0]);
          rx_phase  = tro_pkg::PH_OPT;
        end
        tro_pkg::CH_DMARK: queue_out(tro_pkg::KIND_FLUSH, 8'd0, 1'b0);
        tro_pkg::CH_IP:    queue_out(tro_pkg::KIND_TERM, chars.intr, 1'b0);
        tro_pkg::CH_EC:    queue_out(tro_pkg::KIND_TERM, chars.erase, 1'b0);
        tro_pkg::CH_EL:    queue_out(tro_pkg::KIND_TERM, chars.kill, 1'b0);
        tro_pkg::CH_AO: begin
          queue_out(tro_pkg::KIND_NET, tro_pkg::CH_IAC, 1'b0);
          queue_out(tro_pkg::KIND_NET, tro_pkg::CH_DMARK, 1'b1);
          queue_out(tro_pkg::KIND_TERM, chars.flush, 1'b0);
        end
        default: ;
      endcase
    end else begin
      settle_option(b);
      rx_phase = tro_pkg::PH_DATA;
    end
  endtask

  task automatic await_outputs();
    out_item_t item;
    for (int i = 0; i < step_out.size(); i++) begin
      item.res  = step_out[i];
      item.last = (i == step_out.size() - 1);
      item.echo = echo_mode;
      item.ga   = ga_on;
      item.bin  = local_on[tro_pkg::OPT_BINARY];
      awaited.push_back(item);
    end
  endtask

  task automatic send_request(logic cmd, logic [7:0] b);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic feed(logic cmd, logic [7:0] b);
    send_request(cmd, b);
    decode_rx_request(cmd, b);
    await_outputs();
  endtask

  task automatic drain();
    int spins;
    spins = 0;
    s_axis_tvalid <= 1'b0;
    while (awaited.size() != 0 && spins < DrainLimit) begin
      @(posedge clk_i);
      spins++;
    end
    // a trailing request may give no result yet still be in flight
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic load_chars(logic [7:0] intr, logic [7:0] erase,
                            logic [7:0] kill, logic [7:0] flush);
    logic [1:0] regs [4];
    logic [7:0] vals [4];
    regs = '{tro_pkg::REG_INTERRUPT, tro_pkg::REG_ERASE, tro_pkg::REG_KILL,
             tro_pkg::REG_FLUSH};
    vals = '{intr, erase, kill, flush};
    for (int r = 0; r < 4; r++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= vals[r];
      @(posedge clk_i);
      case (regs[r])
        tro_pkg::REG_INTERRUPT: chars.intr  = vals[r];
        tro_pkg::REG_ERASE:     chars.erase = vals[r];
        tro_pkg::REG_KILL:      chars.kill  = vals[r];
        default:                chars.flush = vals[r];
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_traffic(int n);
    int         start;
    int         pick;
    logic [7:0] arg;
    start = sent;
    while (sent - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // well-formed negotiation, biased towards the options with a policy
        case ($urandom_range(0, 9))
          0, 1:    arg = tro_pkg::OPT_BINARY;
          2, 3:    arg = tro_pkg::OPT_ECHO;
          4, 5:    arg = tro_pkg::OPT_SGA;
          6:       arg = tro_pkg::OPT_TM;
          default: arg = 8'($urandom);
        endcase
        feed(1'b0, tro_pkg::CH_IAC);
        feed(1'b0, tro_pkg::CH_WILL + 8'($urandom_range(0, 3)));
        feed(1'b0, arg);
      end else if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:       arg = tro_pkg::CH_IP;
          1:       arg = tro_pkg::CH_EC;
          2:       arg = tro_pkg::CH_EL;
          3:       arg = tro_pkg::CH_AO;
          4:       arg = tro_pkg::CH_DMARK;
          5:       arg = tro_pkg::CH_NOP;
          6:       arg = tro_pkg::CH_GA;
          7:       arg = tro_pkg::CH_IAC;
          default: arg = 8'($urandom);
        endcase
        feed(1'b0, tro_pkg::CH_IAC);
        feed(1'b0, arg);
      end else if (pick < 68) begin
        feed(1'b1, 8'($urandom));
      end else if (pick < 90) begin
        case ($urandom_range(0, 4))
          0:       arg = tro_pkg::CH_LF;
          1:       arg = tro_pkg::CH_NUL;
          2:       arg = tro_pkg::CH_CR;
          default: arg = 8'($urandom_range(0, 254));
        endcase
        if ($urandom_range(0, 1) != 0) feed(1'b0, tro_pkg::CH_CR);
        feed(1'b0, arg);
      end else begin
        // broken sequence: idle inside it, sometimes cut after the verb
        feed(1'b0, tro_pkg::CH_IAC);
        feed(1'b1, 8'($urandom));
        if ($urandom_range(0, 1) != 0) begin
          feed(1'b0, tro_pkg::CH_WILL + 8'($urandom_range(0, 3)));
        end
      end
    end
  endtask

  // Receiver side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      checked++;
      if (awaited.size() == 0) begin
        report("unexpected result", int'(m_axis_tdata), 0);
      end else begin
        want = awaited.pop_front();
        if (m_axis_tuser != want.res.kind) begin
          report("kind", int'(m_axis_tuser), int'(want.res.kind));
        end
        if (m_axis_tdata[7:0] != want.res.value) begin
          report("value", int'(m_axis_tdata[7:0]), int'(want.res.value));
        end
        if (m_axis_tdata[8] != want.res.push) begin
          report("push", int'(m_axis_tdata[8]), int'(want.res.push));
        end
        if (m_axis_tdata[10:9] != want.echo) begin
          report("echo", int'(m_axis_tdata[10:9]), int'(want.echo));
        end
        if (m_axis_tdata[11] != want.ga) begin
          report("go_ahead", int'(m_axis_tdata[11]), int'(want.ga));
        end
        if (m_axis_tdata[12] != want.bin) begin
          report("binary", int'(m_axis_tdata[12]), int'(want.bin));
        end
        if (m_axis_tdata[15:13] != 3'd0) begin
          report("padding", int'(m_axis_tdata[15:13]), 0);
        end
        if (m_axis_tlast != want.last) begin
          report("last", int'(m_axis_tlast), int'(want.last));
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DirTable); i++) begin
      send_request(DirTable[i].cmd, DirTable[i].b);
      decode_rx_request(DirTable[i].cmd, DirTable[i].b);
      if (DirTable[i].typed) begin
        step_out.delete();
        for (int k = 0; k < DirTable[i].n; k++) step_out.push_back(DirTable[i].r[k]);
      end
      await_outputs();
    end

    // hold the sender until every result is out, then reprogram
    drain();
    load_chars(8'h00, 8'h00, 8'h00, 8'h00);
    random_traffic(PhaseItems);

    drain();
    load_chars(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    src_gap_pct  = 54;
    sink_gap_pct = 21;
    random_traffic(PhaseItems);

    drain();
    load_chars(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    hold_req     = 1'b1;
    random_traffic(PhaseItems);

    drain();
    if (awaited.size() != 0) begin
      report("results never arrived", awaited.size(), 0);
    end
    $display("tb_top: %0d requests sent, %0d results checked, %0d option replies",
             sent, checked, replies);
    $display("tb_top: terminal characters at reset, all-zero, all-one and random");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
